// ===== design/ffa_pkg.sv =====
package ffa_pkg;

    localparam int ARENA_BYTES_DEF     = 1024;
    localparam int HEADER_BYTES_DEF    = 4;
    localparam int MIN_BLOCK_BYTES_DEF = 16;
    localparam int ARENA_FLOOR         = 16;
    localparam int ARENA_RESET         = 1024;
    localparam int ADDR_W              = 10;
    localparam int CFG_W               = 11;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_ZERO  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_WALK,
        S_A_WCUR,
        S_A_WEXT,
        S_A_LINK,
        S_F_HDR,
        S_F_WALK,
        S_F_CHK,
        S_F_WPREV,
        S_F_WCUR
    } t_state;

endpackage

// ===== design/ffa_ram.sv =====
module ffa_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/first_fit_free_list_allocator.sv =====
// First-fit heap allocator over a byte arena of up to ARENA_BYTES. Block
// headers ({payload size, next free}) live in one single-port-read RAM; the
// free list is kept in address order and walked one node per cycle. A
// transaction is taken when start is high, busy is low and i_cfg_we is low;
// exactly one result follows, shown for one cycle with o_valid, and it cannot
// be held off. An allocate walks the free list to the first block that fits,
// writes the kept part and then the remainder when the block is split, and
// relinks the predecessor or the head; when nothing fits it ends with no fit,
// and a zero-size allocate or one against an empty list answers from idle.
// A free reads the freed block's header, walks to the first free block at or
// above it, checks for overlap, relinks a predecessor that does not touch the
// block and writes the merged header; a bad address, a header that runs past
// the arena or an overlap ends it with a failure status.
// busy drops in the cycle the result shows, so the next transaction can be
// taken at the edge that takes the result. The list walk through the header
// RAM sets the rate. After reset the block writes the initial header before
// it takes a transaction. Writing the arena size rebuilds the list as a
// single free block; write it only while idle, the block does not enforce it.
module first_fit_free_list_allocator #(
    parameter int ARENA_BYTES     = ffa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES    = ffa_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffa_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cmd,
    input  logic [ffa_pkg::ADDR_W-1:0]   i_request_size,
    input  logic [ffa_pkg::ADDR_W-1:0]   i_payload_addr,
    input  logic                         i_cfg_we,
    input  logic [ffa_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [ffa_pkg::ADDR_W-1:0]   o_granted_addr
);

    // pointer width holds ARENA_BYTES itself (end-of-list marker)
    localparam int PW = $clog2(ARENA_BYTES + 1);
    localparam int IW = $clog2(ARENA_BYTES);
    localparam int XW = ((PW > ffa_pkg::CFG_W) ? PW : ffa_pkg::CFG_W) + 2;
    localparam logic [PW-1:0] NO_BLK  = PW'(ARENA_BYTES);
    localparam logic [XW-1:0] HDR     = XW'(HEADER_BYTES);
    localparam logic [XW-1:0] MINB    = XW'(MIN_BLOCK_BYTES);
    localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
    localparam logic [XW-1:0] FLOOR_X = XW'(ffa_pkg::ARENA_FLOOR);
    localparam logic [PW-1:0] ARENA_RST =
        PW'((ffa_pkg::ARENA_RESET > ARENA_BYTES) ? ARENA_BYTES : ffa_pkg::ARENA_RESET);

    ffa_pkg::t_state r_state, n_state;

    // header RAM: word = {size, next}
    logic          wr_en;
    logic [IW-1:0] wr_addr, rd_addr;
    logic [2*PW-1:0] wr_data, rd_data;

    ffa_ram #(.WIDTH(2 * PW), .DEPTH(ARENA_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // list and arena state
    logic [PW-1:0] r_arena, n_arena;
    logic [PW-1:0] r_head, n_head;
    logic          r_empty, n_empty;
    // walk registers
    logic [ffa_pkg::ADDR_W-1:0] r_req, n_req;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_prev, n_prev;
    logic [PW-1:0] r_prev_size, n_prev_size;
    logic [PW-1:0] r_steps, n_steps;
    // allocate split
    logic [PW-1:0] r_keep, n_keep;
    logic [PW-1:0] r_cur_next, n_cur_next;
    logic [PW-1:0] r_ext, n_ext;
    logic [PW-1:0] r_ext_size, n_ext_size;
    logic [PW-1:0] r_succ, n_succ;
    logic [PW-1:0] r_repl, n_repl;
    logic          r_split, n_split;
    // free
    logic [PW-1:0] r_blk, n_blk;
    logic [PW-1:0] r_bsize, n_bsize;
    logic [XW-1:0] r_end, n_end;
    logic [PW-1:0] r_nxt, n_nxt;
    logic [PW-1:0] r_nsize, n_nsize;
    logic [PW-1:0] r_nnext, n_nnext;
    logic [2*PW-1:0] r_cur_word, n_cur_word;
    // result
    logic                       r_valid, n_valid;
    ffa_pkg::t_status           r_status, n_status;
    logic [ffa_pkg::ADDR_W-1:0] r_grant, n_grant;

    // shared terms
    logic [PW-1:0] rd_size, rd_next, rd_succ, first;
    logic [XW-1:0] pa_x, blk_x, cfg_x, cfg_sat, req_x;
    logic          free_bad0, fit, a_cont;
    logic          do_split_c, big_c;
    logic [XW-1:0] ext_c, ext_size_c, hdr_end_c;
    logic          f_adv;
    logic [XW-1:0] pend, cur_size_c;
    logic          f_bad, merge_prev, merge_next;
    logic [PW-1:0] nn_succ;

    assign rd_size = rd_data[2*PW-1:PW];
    assign rd_next = rd_data[PW-1:0];
    assign rd_succ = (rd_next < r_arena) ? rd_next : NO_BLK;
    assign first   = (r_empty || (r_head >= r_arena)) ? NO_BLK : r_head;

    assign pa_x      = XW'(i_payload_addr);
    assign blk_x     = pa_x - HDR;
    assign free_bad0 = (pa_x < HDR) || (blk_x >= XW'(r_arena));

    assign cfg_x   = XW'(i_cfg_wdata);
    assign cfg_sat = (cfg_x < FLOOR_X) ? FLOOR_X : ((cfg_x > ARENA_X) ? ARENA_X : cfg_x);

    // allocate walk
    assign req_x  = XW'(r_req);
    assign fit    = XW'(rd_size) >= req_x;
    assign a_cont = (rd_succ != NO_BLK) && ((XW'(r_steps) + XW'(1)) < ARENA_X);
    assign big_c  = (req_x + HDR) > MINB;
    assign ext_c  = big_c ? (XW'(r_cur) + HDR + req_x) : (XW'(r_cur) + MINB);
    assign ext_size_c = big_c ? (XW'(rd_size) - req_x - HDR) : (XW'(rd_size) - MINB);
    assign do_split_c = ((req_x + MINB) < XW'(rd_size)) && (ext_c < XW'(r_arena));

    // free walk and checks
    assign hdr_end_c  = XW'(r_blk) + HDR + XW'(rd_size);
    assign f_adv      = (r_nxt < r_blk) && (XW'(r_steps) < ARENA_X);
    assign pend       = XW'(r_prev) + HDR + XW'(r_prev_size);
    assign f_bad      = (r_nxt == r_blk)
                     || ((r_prev != NO_BLK) && (pend > XW'(r_blk)))
                     || ((r_nxt != NO_BLK) && (r_end > XW'(r_nxt)));
    assign merge_prev = (r_prev != NO_BLK) && (pend == XW'(r_blk));
    // merged or not, the current block ends where the freed block ends
    assign merge_next = (r_nxt != NO_BLK) && (r_end == XW'(r_nxt));
    assign nn_succ    = (r_nnext < r_arena) ? r_nnext : NO_BLK;
    assign cur_size_c = (merge_prev ? (XW'(r_prev_size) + HDR + XW'(r_bsize)) : XW'(r_bsize))
                      + (merge_next ? (HDR + XW'(r_nsize)) : '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffa_pkg::S_INIT: n_state = ffa_pkg::S_IDLE;
            ffa_pkg::S_IDLE: begin
                if (start && !i_cfg_we) begin
                    if (i_cmd == ffa_pkg::CMD_ALLOC) begin
                        if ((i_request_size != '0) && (first != NO_BLK)) begin
                            n_state = ffa_pkg::S_A_WALK;
                        end
                    end else if (!free_bad0) begin
                        n_state = ffa_pkg::S_F_HDR;
                    end
                end
            end
            ffa_pkg::S_A_WALK: begin
                if (fit) begin
                    n_state = do_split_c ? ffa_pkg::S_A_WCUR : ffa_pkg::S_A_LINK;
                end else if (!a_cont) begin
                    n_state = ffa_pkg::S_IDLE;
                end
            end
            ffa_pkg::S_A_WCUR: n_state = ffa_pkg::S_A_WEXT;
            ffa_pkg::S_A_WEXT: n_state = ffa_pkg::S_A_LINK;
            ffa_pkg::S_A_LINK: n_state = ffa_pkg::S_IDLE;
            ffa_pkg::S_F_HDR: begin
                if (hdr_end_c > XW'(r_arena)) begin
                    n_state = ffa_pkg::S_IDLE;
                end else if (first == NO_BLK) begin
                    n_state = ffa_pkg::S_F_CHK;
                end else begin
                    n_state = ffa_pkg::S_F_WALK;
                end
            end
            ffa_pkg::S_F_WALK: begin
                if (!f_adv || (rd_succ == NO_BLK)) begin
                    n_state = ffa_pkg::S_F_CHK;
                end
            end
            ffa_pkg::S_F_CHK: begin
                if (f_bad) begin
                    n_state = ffa_pkg::S_IDLE;
                end else if (!merge_prev && (r_prev != NO_BLK)) begin
                    n_state = ffa_pkg::S_F_WPREV;
                end else begin
                    n_state = ffa_pkg::S_F_WCUR;
                end
            end
            ffa_pkg::S_F_WPREV: n_state = ffa_pkg::S_F_WCUR;
            ffa_pkg::S_F_WCUR:  n_state = ffa_pkg::S_IDLE;
            default:            n_state = ffa_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM port and result
    always_comb begin
        n_arena = r_arena;   n_head = r_head;     n_empty = r_empty;
        n_req = r_req;       n_cur = r_cur;       n_prev = r_prev;
        n_prev_size = r_prev_size;                n_steps = r_steps;
        n_keep = r_keep;     n_cur_next = r_cur_next;
        n_ext = r_ext;       n_ext_size = r_ext_size;
        n_succ = r_succ;     n_repl = r_repl;     n_split = r_split;
        n_blk = r_blk;       n_bsize = r_bsize;   n_end = r_end;
        n_nxt = r_nxt;       n_nsize = r_nsize;   n_nnext = r_nnext;
        n_cur_word = r_cur_word;
        n_valid = 1'b0;      n_status = r_status; n_grant = r_grant;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {PW'(XW'(r_arena) - HDR), NO_BLK};
        rd_addr = IW'(first);

        unique case (r_state)
            ffa_pkg::S_INIT: wr_en = 1'b1;
            ffa_pkg::S_IDLE: begin
                if (start && !i_cfg_we) begin
                    n_req   = i_request_size;
                    n_prev  = NO_BLK;
                    n_steps = '0;
                    n_grant = '0;
                    if (i_cmd == ffa_pkg::CMD_ALLOC) begin
                        n_cur = first;
                        if (i_request_size == '0) begin
                            n_valid  = 1'b1;
                            n_status = ffa_pkg::ST_ZERO;
                        end else if (first == NO_BLK) begin
                            n_valid  = 1'b1;
                            n_status = ffa_pkg::ST_NOFIT;
                        end
                    end else begin
                        n_blk   = PW'(blk_x);
                        rd_addr = IW'(blk_x);
                        if (free_bad0) begin
                            n_valid  = 1'b1;
                            n_status = ffa_pkg::ST_NOFIT;
                        end
                    end
                end
            end
            ffa_pkg::S_A_WALK: begin
                if (fit) begin
                    n_keep     = big_c ? PW'(r_req) : PW'(MINB - HDR);
                    n_cur_next = rd_next;
                    n_ext      = PW'(ext_c);
                    n_ext_size = PW'(ext_size_c);
                    n_succ     = rd_succ;
                    n_split    = do_split_c;
                    n_repl     = do_split_c ? PW'(ext_c) : rd_succ;
                end else begin
                    n_prev      = r_cur;
                    n_prev_size = rd_size;
                    n_cur       = rd_succ;
                    n_steps     = r_steps + PW'(1);
                    rd_addr     = IW'(rd_succ);
                    if (!a_cont) begin
                        n_valid  = 1'b1;
                        n_status = ffa_pkg::ST_NOFIT;
                    end
                end
            end
            ffa_pkg::S_A_WCUR: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_cur);
                wr_data = {r_keep, r_cur_next};
            end
            ffa_pkg::S_A_WEXT: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_ext);
                wr_data = {r_ext_size, r_succ};
            end
            ffa_pkg::S_A_LINK: begin
                if (r_prev == NO_BLK) begin
                    if (r_repl == NO_BLK) begin
                        n_empty = 1'b1;
                    end else begin
                        n_head = r_repl;
                    end
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = IW'(r_prev);
                    wr_data = {r_prev_size, r_repl};
                end
                n_valid  = 1'b1;
                n_status = ffa_pkg::ST_DONE;
                n_grant  = ffa_pkg::ADDR_W'(XW'(r_cur) + HDR);
            end
            ffa_pkg::S_F_HDR: begin
                n_bsize = rd_size;
                n_end   = hdr_end_c;
                n_nxt   = first;
                rd_addr = IW'(first);
                if (hdr_end_c > XW'(r_arena)) begin
                    n_valid  = 1'b1;
                    n_status = ffa_pkg::ST_NOFIT;
                end
            end
            ffa_pkg::S_F_WALK: begin
                if (f_adv) begin
                    n_prev      = r_nxt;
                    n_prev_size = rd_size;
                    n_nxt       = rd_succ;
                    n_steps     = r_steps + PW'(1);
                    rd_addr     = IW'(rd_succ);
                end else begin
                    n_nsize = rd_size;
                    n_nnext = rd_next;
                end
            end
            ffa_pkg::S_F_CHK: begin
                n_cur      = merge_prev ? r_prev : r_blk;
                n_cur_word = {PW'(cur_size_c), merge_next ? nn_succ : r_nxt};
                if (f_bad) begin
                    n_valid  = 1'b1;
                    n_status = ffa_pkg::ST_NOFIT;
                end else if (!merge_prev && (r_prev == NO_BLK)) begin
                    n_head = r_blk;
                end
            end
            ffa_pkg::S_F_WPREV: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_prev);
                wr_data = {r_prev_size, r_blk};
            end
            ffa_pkg::S_F_WCUR: begin
                wr_en    = 1'b1;
                wr_addr  = IW'(r_cur);
                wr_data  = r_cur_word;
                n_empty  = 1'b0;
                n_valid  = 1'b1;
                n_status = ffa_pkg::ST_DONE;
            end
            default: ;
        endcase

        // arena size write: list becomes one block at offset 0
        if (i_cfg_we) begin
            n_arena = PW'(cfg_sat);
            n_head  = '0;
            n_empty = 1'b0;
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {PW'(cfg_sat - HDR), NO_BLK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffa_pkg::S_INIT;
            r_arena  <= ARENA_RST;
            r_head   <= '0;
            r_empty  <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= ffa_pkg::ST_DONE;
            r_grant  <= '0;
        end else begin
            r_state  <= n_state;
            r_arena  <= n_arena;
            r_head   <= n_head;
            r_empty  <= n_empty;
            r_valid  <= n_valid;
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;           r_cur <= n_cur;         r_prev <= n_prev;
        r_prev_size <= n_prev_size;                       r_steps <= n_steps;
        r_keep <= n_keep;         r_cur_next <= n_cur_next;
        r_ext <= n_ext;           r_ext_size <= n_ext_size;
        r_succ <= n_succ;         r_repl <= n_repl;       r_split <= n_split;
        r_blk <= n_blk;           r_bsize <= n_bsize;     r_end <= n_end;
        r_nxt <= n_nxt;           r_nsize <= n_nsize;     r_nnext <= n_nnext;
        r_cur_word <= n_cur_word;
    end

    assign busy           = (r_state != ffa_pkg::S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_granted_addr = r_grant;

    // a result is never raised straight out of the init state
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) != ffa_pkg::S_INIT))
        else $error("result without transaction");

    // grants only travel with a successful status
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ffa_pkg::ST_DONE)) |-> (o_granted_addr == '0))
        else $error("nonzero grant on failure");

    // the header RAM is left alone while idle, bar arena rebuilds
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ffa_pkg::S_IDLE) && !i_cfg_we) |-> !wr_en)
        else $error("header write while idle");

    // a split only follows a fitting block
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffa_pkg::S_A_WCUR) |-> ($past(r_state) == ffa_pkg::S_A_WALK) && r_split)
        else $error("split write out of order");

endmodule
